// ----- hdl/lfu_cache_lru_tiebreak_top_macros.svh -----
// Assertion macros shared by the cache RTL. They expect aclk and aresetn in scope.
`ifndef LFU_CACHE_LRU_TIEBREAK_TOP_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LFU_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lfu_pkg.sv -----
package lfu_pkg;

    localparam int MAX_ENTRIES_DEFAULT = 16;
    localparam int CAP_W               = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam int COUNT_W             = 32;
    localparam int KEY_W               = 32;
    localparam int VALUE_W             = 32;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic                       op;
        logic signed [KEY_W-1:0]    key;
        logic signed [VALUE_W-1:0]  value;
    } in_word_t;

    typedef struct packed {
        logic                       hit;
        logic signed [VALUE_W-1:0]  read_value;
        logic                       evicted;
        logic signed [KEY_W-1:0]    evicted_key;
        logic                       ignored;
    } out_word_t;

endpackage

// ----- hdl/lfu_entry_ram.sv -----
module lfu_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                      rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/lfu_cache_lru_tiebreak_top.sv -----
// Key-value cache with least-frequently-used replacement and least-recently-used tie break.
// Each input word is a get or a put of a 32-bit key; each one produces exactly one result
// word that reports hit, the read value, an eviction and its key, or a put dropped because
// the capacity register is zero. Entries live in a single memory of MAX_ENTRIES rows that a
// small sequencer walks one row per cycle: each word is taken, then all MAX_ENTRIES rows
// are scanned through the memory's read port, and then the chosen row is decided and
// written, waiting while an earlier result is not yet accepted. The scan finds
// the matching key, the first free row and the victim at once. The recency ages that an
// update causes are written back during the scan of the next word, through the same memory
// write port, so no separate update pass is needed. s_ready is high only while the sequencer
// waits for a word; a finished result sits in an output register, so the next word can be
// taken while the result still waits for m_ready. The store needs no clearing pass after
// reset: per-row valid bits are cleared at once. The capacity register is written through
// cfg_valid/cfg_data and must only change while the cache is idle.

`include "lfu_cache_lru_tiebreak_top_macros.svh"

module lfu_cache_lru_tiebreak_top #(
    parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  lfu_pkg::in_word_t        s_word,

    output logic                     m_valid,
    input  logic                     m_ready,
    output lfu_pkg::out_word_t       m_word,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(MAX_ENTRIES);

    // One row of the entry memory. Rank zero is the most recent entry.
    typedef struct packed {
        logic [lfu_pkg::KEY_W-1:0]   key;
        logic [lfu_pkg::VALUE_W-1:0] value;
        logic [lfu_pkg::COUNT_W-1:0] count;
        logic [RANK_W-1:0]           rank;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Control state.
    lfu_pkg::state_t        state_reg, state_next;
    logic [lfu_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;

    // Item and scan bookkeeping.
    lfu_pkg::in_word_t      item_reg, item_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       match_slot_reg, match_slot_next;
    entry_t                 match_entry_reg, match_entry_next;
    logic                   free_got_reg, free_got_next;
    logic [IDX_W-1:0]       free_slot_reg, free_slot_next;
    logic                   vic_got_reg, vic_got_next;
    logic [IDX_W-1:0]       vic_slot_reg, vic_slot_next;
    logic [lfu_pkg::KEY_W-1:0]   vic_key_reg, vic_key_next;
    logic [lfu_pkg::COUNT_W-1:0] vic_count_reg, vic_count_next;
    logic [RANK_W-1:0]      vic_rank_reg, vic_rank_next;

    // Pending recency update, applied while the next word scans the memory.
    logic                   pend_all_reg, pend_all_next;
    logic [IDX_W-1:0]       pend_slot_reg, pend_slot_next;
    logic [RANK_W-1:0]      pend_thr_reg, pend_thr_next;

    lfu_pkg::out_word_t     out_word_reg, out_word_next;

    // Memory port signals.
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    entry_t                 ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    entry_t                 rd_entry;

    // Scan datapath.
    logic                   cur_valid;
    logic                   age_cur;
    logic [RANK_W-1:0]      adj_rank;
    logic                   cache_full;
    logic                   proceed;
    logic [lfu_pkg::COUNT_W-1:0] bumped_count;

    lfu_entry_ram #(
        .DEPTH  (MAX_ENTRIES),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    assign s_ready   = (state_reg == lfu_pkg::ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_word    = out_word_reg;
    assign cfg_ready = 1'b1;

    // Row zero is read on the accepting edge, so its data is there in the first scan cycle.
    assign ram_raddr = (state_reg == lfu_pkg::ST_SCAN) ? IDX_W'(scan_idx_reg + 1'b1) : '0;

    // Age the row under the scan if the previous update asks for it.
    assign cur_valid = valid_reg[scan_idx_reg];
    assign age_cur   = pend_reg && cur_valid && (scan_idx_reg != pend_slot_reg) &&
                       (pend_all_reg || (rd_entry.rank < pend_thr_reg));
    assign adj_rank  = age_cur ? RANK_W'(rd_entry.rank + 1'b1) : rd_entry.rank;

    // Full when occupancy reaches the capacity or the number of rows.
    assign cache_full = (CMP_W'(occ_reg) >= CMP_W'(cap_reg)) || (occ_reg == OCC_FULL);
    assign proceed    = !out_valid_reg || m_ready;
    assign bumped_count = (match_entry_reg.count == '1) ? match_entry_reg.count
                                                        : match_entry_reg.count + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lfu_pkg::ST_IDLE;
            cap_reg       <= lfu_pkg::CAP_RESET;
            valid_reg     <= '0;
            occ_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        scan_idx_reg    <= scan_idx_next;
        found_reg       <= found_next;
        match_slot_reg  <= match_slot_next;
        match_entry_reg <= match_entry_next;
        free_got_reg    <= free_got_next;
        free_slot_reg   <= free_slot_next;
        vic_got_reg     <= vic_got_next;
        vic_slot_reg    <= vic_slot_next;
        vic_key_reg     <= vic_key_next;
        vic_count_reg   <= vic_count_next;
        vic_rank_reg    <= vic_rank_next;
        pend_all_reg    <= pend_all_next;
        pend_slot_reg   <= pend_slot_next;
        pend_thr_reg    <= pend_thr_next;
        out_word_reg    <= out_word_next;
    end

    always_comb begin
        state_next       = state_reg;
        cap_next         = cap_reg;
        valid_next       = valid_reg;
        occ_next         = occ_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        item_next        = item_reg;
        scan_idx_next    = scan_idx_reg;
        found_next       = found_reg;
        match_slot_next  = match_slot_reg;
        match_entry_next = match_entry_reg;
        free_got_next    = free_got_reg;
        free_slot_next   = free_slot_reg;
        vic_got_next     = vic_got_reg;
        vic_slot_next    = vic_slot_reg;
        vic_key_next     = vic_key_reg;
        vic_count_next   = vic_count_reg;
        vic_rank_next    = vic_rank_reg;
        pend_all_next    = pend_all_reg;
        pend_slot_next   = pend_slot_reg;
        pend_thr_next    = pend_thr_reg;
        out_word_next    = out_word_reg;
        ram_we           = 1'b0;
        ram_waddr        = scan_idx_reg;
        ram_wdata        = rd_entry;

        if (cfg_valid) begin
            cap_next = cfg_data;
        end

        case (state_reg)
            lfu_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next     = s_word;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    free_got_next = 1'b0;
                    vic_got_next  = 1'b0;
                    state_next    = lfu_pkg::ST_SCAN;
                end
            end

            lfu_pkg::ST_SCAN: begin
                // Write back the aged rank of this row.
                ram_we         = age_cur;
                ram_wdata.rank = adj_rank;

                if (cur_valid && !found_reg && (rd_entry.key == item_reg.key)) begin
                    found_next            = 1'b1;
                    match_slot_next       = scan_idx_reg;
                    match_entry_next      = rd_entry;
                    match_entry_next.rank = adj_rank;
                end
                if (!cur_valid && !free_got_reg) begin
                    free_got_next  = 1'b1;
                    free_slot_next = scan_idx_reg;
                end
                // Lowest count wins; among equal counts the oldest (highest rank) wins.
                if (cur_valid && (!vic_got_reg || (rd_entry.count < vic_count_reg) ||
                    ((rd_entry.count == vic_count_reg) && (adj_rank > vic_rank_reg)))) begin
                    vic_got_next   = 1'b1;
                    vic_slot_next  = scan_idx_reg;
                    vic_key_next   = rd_entry.key;
                    vic_count_next = rd_entry.count;
                    vic_rank_next  = adj_rank;
                end

                if (scan_idx_reg == LAST_IDX) begin
                    pend_next  = 1'b0;
                    state_next = lfu_pkg::ST_DECIDE;
                end else begin
                    scan_idx_next = IDX_W'(scan_idx_reg + 1'b1);
                end
            end

            lfu_pkg::ST_DECIDE: begin
                if (proceed) begin
                    out_word_next  = '0;
                    out_valid_next = 1'b1;
                    state_next     = lfu_pkg::ST_IDLE;
                    ram_wdata.key   = item_reg.key;
                    ram_wdata.value = item_reg.value;
                    ram_wdata.count = lfu_pkg::COUNT_W'(1);
                    ram_wdata.rank  = '0;

                    if ((item_reg.op == lfu_pkg::OP_GET) ||
                        ((cap_reg != '0) && found_reg)) begin
                        // Hit on either op: bump the count and make the entry most recent.
                        if (found_reg) begin
                            out_word_next.hit = 1'b1;
                            if (item_reg.op == lfu_pkg::OP_GET) begin
                                out_word_next.read_value = match_entry_reg.value;
                                ram_wdata.value          = match_entry_reg.value;
                            end
                            ram_we          = 1'b1;
                            ram_waddr       = match_slot_reg;
                            ram_wdata.count = bumped_count;
                            pend_next       = 1'b1;
                            pend_all_next   = 1'b0;
                            pend_slot_next  = match_slot_reg;
                            pend_thr_next   = match_entry_reg.rank;
                        end
                    end else if (cap_reg == '0) begin
                        out_word_next.ignored = 1'b1;
                    end else if (!cache_full) begin
                        // New key into the first free row; every other entry ages.
                        ram_we                     = 1'b1;
                        ram_waddr                  = free_slot_reg;
                        valid_next[free_slot_reg]  = 1'b1;
                        occ_next                   = OCC_W'(occ_reg + 1'b1);
                        pend_next                  = 1'b1;
                        pend_all_next              = 1'b1;
                        pend_slot_next             = free_slot_reg;
                        pend_thr_next              = '0;
                    end else begin
                        // Replace the victim in place.
                        out_word_next.evicted     = 1'b1;
                        out_word_next.evicted_key = vic_key_reg;
                        ram_we                    = 1'b1;
                        ram_waddr                 = vic_slot_reg;
                        pend_next                 = 1'b1;
                        pend_all_next             = 1'b0;
                        pend_slot_next            = vic_slot_reg;
                        pend_thr_next             = vic_rank_reg;
                    end
                end
            end

            default: begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    `LFU_ASSERT_ALWAYS(a_occ_matches_valid, $countones(valid_reg) == occ_reg, "occupancy count disagrees with valid bits")
    `LFU_ASSERT_NEXT(a_accept_starts_scan, s_valid && s_ready, state_reg == lfu_pkg::ST_SCAN && scan_idx_reg == '0, "accepted word did not start a scan")
    `LFU_ASSERT_NEXT(a_decide_waits, state_reg == lfu_pkg::ST_DECIDE && out_valid_reg && !m_ready, state_reg == lfu_pkg::ST_DECIDE && out_valid_reg, "result overwritten while output stalled")
    `LFU_ASSERT_ALWAYS(a_no_pend_during_decide, !(state_reg == lfu_pkg::ST_DECIDE && pend_reg), "recency update still pending after scan")

endmodule

// ----- tb/lfu_cache_checker.sv -----
module lfu_cache_checker #(
    parameter int SLOTS = lfu_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    input  logic                      s_ready,
    input  lfu_pkg::in_word_t         s_word,

    input  logic                      m_valid,
    input  logic                      m_ready,
    input  lfu_pkg::out_word_t        m_word,

    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_data,

    output int                        mismatches,
    output int                        awaiting
);

    localparam int AGE_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic                        slot_used [SLOTS];
    logic [lfu_pkg::KEY_W-1:0]   slot_key  [SLOTS];
    logic [lfu_pkg::VALUE_W-1:0] slot_data [SLOTS];
    logic [lfu_pkg::COUNT_W-1:0] slot_uses [SLOTS];
    logic [AGE_W-1:0]            slot_age  [SLOTS];
    int unsigned                 fill_level;
    logic [lfu_pkg::CAP_W-1:0]   capacity;
    lfu_pkg::out_word_t          pending_results [$];
    int                          fail_total = 0;

    // Entry s becomes the most recent; every entry newer than it ages by one.
    function automatic void make_recent(int s, logic [AGE_W-1:0] old_age);
        for (int j = 0; j < SLOTS; j++) begin
            if (slot_used[j] && j != s && slot_age[j] < old_age) begin
                slot_age[j] = slot_age[j] + 1'b1;
            end
        end
        slot_age[s] = '0;
    endfunction

    function automatic void count_use(int s);
        if (slot_uses[s] != '1) begin
            slot_uses[s] = slot_uses[s] + 1'b1;
        end
    endfunction

    function automatic lfu_pkg::out_word_t cache_access(lfu_pkg::in_word_t w);
        lfu_pkg::out_word_t r;
        int                 slot;
        bit                 found;
        bit                 got;
        int unsigned        room;
        r     = '0;
        slot  = 0;
        found = 1'b0;
        got   = 1'b0;
        room  = (int'(capacity) > SLOTS) ? SLOTS : int'(capacity);
        for (int j = 0; j < SLOTS; j++) begin
            if (!found && slot_used[j] && slot_key[j] == w.key) begin
                slot  = j;
                found = 1'b1;
            end
        end
        if (w.op == lfu_pkg::OP_GET) begin
            if (found) begin
                r.hit        = 1'b1;
                r.read_value = slot_data[slot];
                count_use(slot);
                make_recent(slot, slot_age[slot]);
            end
        end else if (room == 0) begin
            r.ignored = 1'b1;
        end else if (found) begin
            r.hit           = 1'b1;
            slot_data[slot] = w.value;
            count_use(slot);
            make_recent(slot, slot_age[slot]);
        end else if (fill_level < room) begin
            for (int j = 0; j < SLOTS; j++) begin
                if (!got && !slot_used[j]) begin
                    slot = j;
                    got  = 1'b1;
                end
            end
            if (got) begin
                for (int j = 0; j < SLOTS; j++) begin
                    if (slot_used[j]) begin
                        slot_age[j] = slot_age[j] + 1'b1;
                    end
                end
                slot_used[slot] = 1'b1;
                slot_key[slot]  = w.key;
                slot_data[slot] = w.value;
                slot_uses[slot] = 1;
                slot_age[slot]  = '0;
                fill_level++;
            end
        end else begin
            // Victim: lowest use count, and the oldest among equal counts.
            for (int j = 0; j < SLOTS; j++) begin
                if (slot_used[j] && (!got || slot_uses[j] < slot_uses[slot] ||
                        (slot_uses[j] == slot_uses[slot] && slot_age[j] > slot_age[slot]))) begin
                    slot = j;
                    got  = 1'b1;
                end
            end
            if (got) begin
                r.evicted       = 1'b1;
                r.evicted_key   = slot_key[slot];
                slot_key[slot]  = w.key;
                slot_data[slot] = w.value;
                slot_uses[slot] = 1;
                make_recent(slot, slot_age[slot]);
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, $signed(want), $signed(got));
            fail_total++;
        end
    endfunction

    always @(posedge aclk) begin
        lfu_pkg::out_word_t want;
        if (!aresetn) begin
            for (int j = 0; j < SLOTS; j++) begin
                slot_used[j] = 1'b0;
            end
            fill_level = 0;
            capacity   = lfu_pkg::CAP_RESET;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity = cfg_data;
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(cache_access(s_word));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word arrived with no expected result waiting");
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(m_word.hit));
                    check_field("read_value", want.read_value, m_word.read_value);
                    check_field("evicted", 32'(want.evicted), 32'(m_word.evicted));
                    check_field("evicted_key", want.evicted_key, m_word.evicted_key);
                    check_field("ignored", 32'(want.ignored), 32'(m_word.ignored));
                end
            end
        end
        mismatches <= fail_total;
        awaiting   <= pending_results.size();
    end

endmodule

// ----- tb/lfu_cache_lru_tiebreak_top_tb.sv -----
// Testbench for the LFU cache with LRU tie break. The top only generates stimulus and
// gives the verdict; the checker beside the block predicts every result word and
// compares it field by field.
module lfu_cache_lru_tiebreak_top_tb;

    // Once every result is back the block is idle; the drain wait only leaves a quiet
    // stretch before a capacity change.
    localparam int DRAIN_CYCLES = 3 * (lfu_pkg::MAX_ENTRIES_DEFAULT + 2);
    localparam int POOL_SIZE    = 24;
    localparam logic [lfu_pkg::KEY_W-1:0] MIN_KEY = 32'h8000_0000;
    localparam logic [lfu_pkg::KEY_W-1:0] MAX_KEY = 32'h7FFF_FFFF;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    lfu_pkg::in_word_t           s_word;
    logic                        m_valid;
    logic                        m_ready;
    lfu_pkg::out_word_t          m_word;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [lfu_pkg::CAP_W-1:0]   cfg_data;

    int                 mismatches;
    int                 awaiting;

    // Odds of starting an idle burst: 0 means never, n means one chance in n per word.
    int                 send_idle_odds;
    int                 recv_stall_odds;
    int                 stall_left = 0;

    // Keys that the random part keeps coming back to, so that gets and puts hit.
    logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    always #6 aclk = ~aclk;

    lfu_cache_lru_tiebreak_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lfu_cache_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // The result side stalls in bursts. It changes only at the falling
    // edge, so the block samples a stable m_ready at every rising edge.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (recv_stall_odds != 0 && $urandom_range(0, recv_stall_odds - 1) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offers one word and returns at the falling edge after it was taken. Valid stays
    // high across back-to-back words; it only drops when an idle burst follows.
    task automatic send_word(input logic op, input logic [lfu_pkg::KEY_W-1:0] key,
                             input logic [lfu_pkg::VALUE_W-1:0] value);
        lfu_pkg::in_word_t w;
        w.op    = op;
        w.key   = key;
        w.value = value;
        s_word  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (send_idle_odds != 0 && $urandom_range(0, send_idle_odds - 1) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
    endtask

    // Stops sending until every expected result has come back, then waits a little
    // longer with the block idle.
    task automatic hold_off();
        s_valid <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // The capacity only changes while the cache is idle.
    task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
        hold_off();
        cfg_data  <= cap;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One random phase at a given capacity. Most keys come from a small pool sized a bit
    // above the usable capacity, so the cache fills, hits and evicts; a tenth of the keys
    // are fresh random words. Part of the pool is renewed each phase.
    task automatic run_phase(input logic [lfu_pkg::CAP_W-1:0] cap, input int words,
                             input int idle_odds, input int stall_odds);
        int                        live;
        logic [lfu_pkg::KEY_W-1:0] key;
        write_capacity(cap);
        send_idle_odds  = idle_odds;
        recv_stall_odds = stall_odds;
        for (int k = 0; k < 8; k++) begin
            key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        end
        live = ((int'(cap) > lfu_pkg::MAX_ENTRIES_DEFAULT) ? lfu_pkg::MAX_ENTRIES_DEFAULT
                                                          : int'(cap)) + 3;
        if (live < 4) begin
            live = 4;
        end
        if (live > POOL_SIZE) begin
            live = POOL_SIZE;
        end
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                key = $urandom;
            end else begin
                key = key_pool[$urandom_range(0, live - 1)];
            end
            send_word(($urandom_range(0, 99) < 55) ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET,
                      key, $urandom);
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_word          = '0;
        m_ready         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        send_idle_odds  = 3;
        recv_stall_odds = 3;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset capacity: a get on the empty cache, then the extreme
        // keys and values, hits on both ops, a get miss and an update of a present key.
        send_word(lfu_pkg::OP_GET, 32'd0, 32'd0);
        send_word(lfu_pkg::OP_PUT, MIN_KEY, MAX_KEY);
        send_word(lfu_pkg::OP_PUT, MAX_KEY, MIN_KEY);
        send_word(lfu_pkg::OP_PUT, 32'd0, 32'hFFFF_FFFF);
        send_word(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'd0);
        send_word(lfu_pkg::OP_GET, MIN_KEY, 32'hFFFF_FFFF);
        send_word(lfu_pkg::OP_GET, MAX_KEY, 32'd0);
        send_word(lfu_pkg::OP_GET, 32'd5, 32'd0);
        send_word(lfu_pkg::OP_PUT, 32'd0, 32'd123);
        send_word(lfu_pkg::OP_GET, 32'd0, 32'd0);

        // Capacity lowered below the four entries held: every new key evicts and occupancy
        // stays where it is.
        write_capacity(5'd2);
        send_word(lfu_pkg::OP_PUT, 32'd11, 32'd1);
        send_word(lfu_pkg::OP_PUT, 32'd12, 32'd2);
        send_word(lfu_pkg::OP_PUT, 32'd13, 32'd3);
        send_word(lfu_pkg::OP_GET, 32'd12, 32'd0);
        send_word(lfu_pkg::OP_PUT, 32'd14, 32'd4);

        // Capacity zero: puts of new and present keys are dropped, gets still hit.
        write_capacity(5'd0);
        send_word(lfu_pkg::OP_PUT, 32'd15, 32'd5);
        send_word(lfu_pkg::OP_PUT, 32'd0, 32'd6);
        send_word(lfu_pkg::OP_GET, 32'd0, 32'd0);
        send_word(lfu_pkg::OP_GET, 32'd14, 32'd0);

        // Capacity above the number of slots behaves as a full sixteen.
        write_capacity(5'd31);
        send_word(lfu_pkg::OP_PUT, 32'd16, 32'd7);
        send_word(lfu_pkg::OP_GET, 32'd16, 32'd0);

        // Random part: a run of capacities with the extremes among them, with idling
        // that varies by phase, including phases with none on one side or both.
        run_phase(5'd16, 110, 3, 3);
        run_phase(5'd31, 110, 0, 2);
        run_phase(5'd1, 100, 2, 0);
        run_phase(5'd5, 110, 4, 4);
        run_phase(5'd0, 60, 3, 2);
        run_phase(5'd3, 110, 0, 0);
        run_phase(5'd8, 110, 2, 5);
        run_phase(5'd20, 110, 5, 2);
        run_phase(5'd2, 100, 3, 3);
        // The last stretch runs at full rate on both sides.
        run_phase(5'd16, 150, 0, 0);

        hold_off();
        if (mismatches == 0 && awaiting == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(12 * 600000);
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lfu_pkg.sv
hdl/lfu_entry_ram.sv
hdl/lfu_cache_lru_tiebreak_top.sv
tb/lfu_cache_checker.sv
tb/lfu_cache_lru_tiebreak_top_tb.sv
